// ===== hdl/pbd1_pkg.sv =====
// Shared types, constants and the Bayer threshold lookup for the 1-bit
// ordered-dither core. No dependencies.
`default_nettype none

package pbd1_pkg;

    localparam int PAL_ENTRIES   = 16;
    localparam int PAL_BITS      = 24 * PAL_ENTRIES;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int CC_W          = 5;
    localparam int IMG_W         = 12;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // register indexes (address bits [5:3])
    localparam logic [2:0] REG_PAL_0       = 3'd0;
    localparam logic [2:0] REG_PAL_1       = 3'd1;
    localparam logic [2:0] REG_PAL_2       = 3'd2;
    localparam logic [2:0] REG_PAL_3       = 3'd3;
    localparam logic [2:0] REG_PAL_4       = 3'd4;
    localparam logic [2:0] REG_PAL_5       = 3'd5;
    localparam logic [2:0] REG_COLOR_COUNT = 3'd6;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd7;

    localparam logic [CC_W-1:0]  CC_RESET  = 5'd16;
    localparam logic [IMG_W-1:0] IMG_RESET = 12'd1;

    typedef logic [3:0] t_cells [16];
    localparam t_cells BAYER_CELLS = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_end;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

    // (r+g+b)/3 <= cell*16+8  is the same as  r+g+b <= cell*48+26
    function automatic logic [9:0] pbd1_limit(input logic [1:0] phase,
                                              input logic [1:0] col);
        logic [3:0] level;
        level = BAYER_CELLS[{phase, col}];
        return 10'({6'd0, level} * 10'd48 + 10'd26);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/palette_bayer_dither_1bit_core.sv =====
// Top level of the 4x4 ordered-dither core: register port and channel wiring.
// Depends on pbd1_pkg, pbd1_pack, pbd1_outq.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   input    | i_valid / o_ready  | i_src_byte (two 4-bit indices)
//   output   | o_valid / i_ready  | o_out_byte, o_row_end
//   config   | psel/penable/...   | paddr[5:3] index, 64-bit data
//
// One source byte per clock while the queue has room: a byte is held in the
// input register, then its 0..2 result bytes enter a 4-entry result queue.
// Results reach o_valid through the input register and the queue registers.
// A byte with two results fills two queue entries, so rows with padding
// stall input briefly when the output side is the limit.
// Reset is synchronous, active low; no clearing pass.
`default_nettype none

module palette_bayer_dither_1bit_core #(
    parameter int MAX_WIDTH = pbd1_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [7:0]                      i_src_byte,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_row_end,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pbd1_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pbd1_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pbd1_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import pbd1_pkg::*;

    logic [PAL_BITS-1:0] r_palette;
    logic [CC_W-1:0]     r_color_count;
    logic [IMG_W-1:0]    r_image_width;
    logic [2:0]          reg_idx;
    logic                wr_en;
    logic                room;
    t_push               push;
    t_result             result;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette     <= '0;
            r_color_count <= CC_RESET;
            r_image_width <= IMG_RESET;
        end else if (wr_en) begin
            case (reg_idx) inside
                [REG_PAL_0:REG_PAL_5]: r_palette[reg_idx * CFG_DATA_W +: CFG_DATA_W] <= pwdata;
                REG_COLOR_COUNT:       r_color_count <= pwdata[CC_W-1:0];
                REG_IMAGE_WIDTH:       r_image_width <= pwdata[IMG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx) inside
            [REG_PAL_0:REG_PAL_5]: prdata = r_palette[reg_idx * CFG_DATA_W +: CFG_DATA_W];
            REG_COLOR_COUNT:       prdata = CFG_DATA_W'(r_color_count);
            REG_IMAGE_WIDTH:       prdata = CFG_DATA_W'(r_image_width);
            default:               prdata = '0;
        endcase
    end

    pbd1_pack #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_src_byte   (i_src_byte),
        .i_room       (room),
        .i_palette    (r_palette),
        .i_color_count(r_color_count),
        .i_image_width(r_image_width),
        .o_push       (push)
    );

    pbd1_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(result)
    );

    assign o_out_byte = result.out_byte;
    assign o_row_end  = result.row_end;

endmodule

`default_nettype wire

// ===== hdl/pbd1_pixel.sv =====
// One pixel: palette lookup, channel sum and threshold compare.
// Depends on pbd1_pkg.
`default_nettype none

module pbd1_pixel (
    input  wire logic [3:0]                  i_index,
    input  wire logic [pbd1_pkg::CC_W-1:0]   i_color_count,
    input  wire logic [pbd1_pkg::PAL_BITS-1:0] i_palette,
    input  wire logic [1:0]                  i_row_phase,
    input  wire logic [1:0]                  i_col,
    output logic                             o_black
);
    import pbd1_pkg::*;

    logic [3:0]  idx;
    logic [23:0] entry;
    logic [9:0]  sum;

    always_comb begin
        // out-of-range index falls back to entry 0
        idx   = ({1'b0, i_index} >= i_color_count) ? 4'd0 : i_index;
        entry = i_palette[{1'b0, idx, 4'd0} + {2'd0, idx, 3'd0} +: 24];
        sum   = {2'd0, entry[23:16]} + {2'd0, entry[15:8]} + {2'd0, entry[7:0]};
        o_black = (sum <= pbd1_limit(i_row_phase, i_col));
    end

endmodule

`default_nettype wire

// ===== hdl/pbd1_pack.sv =====
// Input register, row/column state and bit packing for two pixels per byte.
// Depends on pbd1_pkg and pbd1_pixel.
`default_nettype none

module pbd1_pack #(
    parameter int MAX_WIDTH = pbd1_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_src_byte,
    input  wire logic                          i_room,
    input  wire logic [pbd1_pkg::PAL_BITS-1:0] i_palette,
    input  wire logic [pbd1_pkg::CC_W-1:0]     i_color_count,
    input  wire logic [pbd1_pkg::IMG_W-1:0]    i_image_width,
    output pbd1_pkg::t_push                    o_push
);
    import pbd1_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = ((WB > IMG_W) ? WB : IMG_W) + 1;

    logic          r_in_valid, n_in_valid;
    logic [7:0]    r_src;
    logic [CW-1:0] r_column, n_column;
    logic [1:0]    r_row_phase, n_row_phase;
    logic [7:0]    r_acc, n_acc;
    logic          r_odd, n_odd;

    logic          fire;
    logic [EW-1:0] width, c0, c1, c2, fin;
    logic          v0, v1, b0, b1, full, row_done, emit, pad, odd_after;
    logic [7:0]    acc_after;

    pbd1_pixel u_pix0 (
        .i_index      (r_src[7:4]),
        .i_color_count(i_color_count),
        .i_palette    (i_palette),
        .i_row_phase  (r_row_phase),
        .i_col        (r_column[1:0]),
        .o_black      (b0)
    );

    pbd1_pixel u_pix1 (
        .i_index      (r_src[3:0]),
        .i_color_count(i_color_count),
        .i_palette    (i_palette),
        .i_row_phase  (r_row_phase),
        .i_col        ({r_column[1], 1'b1}),
        .o_black      (b1)
    );

    always_comb begin
        fire    = r_in_valid && i_room;
        o_ready = !r_in_valid || i_room;

        // clamp width to 1..MAX_WIDTH
        width = EW'(i_image_width);
        if (width == '0) begin
            width = EW'(1);
        end else if (width > EW'(MAX_WIDTH)) begin
            width = EW'(MAX_WIDTH);
        end

        c0 = EW'(r_column);
        c1 = c0 + EW'(1);
        c2 = c0 + EW'(2);
        v0 = c0 < width;
        v1 = c1 < width;

        acc_after = r_acc;
        if (v0 && b0) acc_after = acc_after | (8'h80 >> c0[2:0]);
        if (v1 && b1) acc_after = acc_after | (8'h80 >> c1[2:0]);

        fin = v1 ? c2 : (v0 ? c1 : c0);
        full      = v1 && (c1[2:0] == 3'd7);
        row_done  = c2 >= width;
        emit      = full || (row_done && (fin[2:0] != 3'd0));
        odd_after = r_odd ^ emit;
        pad       = row_done && odd_after;

        o_push.cnt             = fire ? ({1'b0, emit} + {1'b0, pad}) : 2'd0;
        o_push.first.out_byte  = emit ? acc_after : 8'd0;
        o_push.first.row_end   = emit ? (row_done && !pad) : 1'b1;
        o_push.second.out_byte = 8'd0;
        o_push.second.row_end  = 1'b1;

        n_in_valid  = fire ? 1'b0 : r_in_valid;
        if (o_ready && i_valid) n_in_valid = 1'b1;

        n_column    = r_column;
        n_row_phase = r_row_phase;
        n_acc       = r_acc;
        n_odd       = r_odd;
        if (fire) begin
            if (row_done) begin
                n_column    = '0;
                n_acc       = 8'd0;
                n_odd       = 1'b0;
                n_row_phase = r_row_phase + 2'd1;
            end else begin
                n_column = c2[CW-1:0];
                n_acc    = full ? 8'd0 : acc_after;
                n_odd    = odd_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_column    <= '0;
            r_row_phase <= 2'd0;
            r_acc       <= 8'd0;
            r_odd       <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_column    <= n_column;
            r_row_phase <= n_row_phase;
            r_acc       <= n_acc;
            r_odd       <= n_odd;
        end
    end

    // capture the byte on transfer
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_src <= i_src_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pbd1_outq.sv =====
// Small result queue: up to two writes and one read per cycle.
// Depends on pbd1_pkg.
`default_nettype none

module pbd1_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pbd1_pkg::t_push i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output pbd1_pkg::t_result    o_result
);
    import pbd1_pkg::*;

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic                 pop;

    always_comb begin
        o_valid  = r_count != '0;
        o_room   = r_count <= Q_CNT_W'(Q_DEPTH - 2);
        o_result = r_mem[r_rd];
        pop      = o_valid && i_ready;
        n_wr     = r_wr + Q_PTR_W'(i_push.cnt);
        n_rd     = r_rd + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(i_push.cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + Q_PTR_W'(1)] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

// ===== test/palette_bayer_dither_1bit_core_tb.sv =====
// Self-checking bench for palette_bayer_dither_1bit_core: a directed table, then
// random register phases, each output byte checked against typed table results or an in-bench dither model.
// Depends on pbd1_pkg and the core RTL.
`timescale 1ns / 100ps

module palette_bayer_dither_1bit_core_tb;

    import pbd1_pkg::*;

    localparam int          MAX_W        = DEF_MAX_WIDTH;
    localparam int          SETTLE_TICKS = 4;
    localparam int          WIDE_BYTES   = 24;
    localparam int          RANDOM_ITEMS = 780;
    localparam int          STEADY_PHASE = 4;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int unsigned DOT_CELL [4][4] = '{
        '{ 0,  8,  2, 10},
        '{12,  4, 14,  6},
        '{ 3, 11,  1,  9},
        '{15,  7, 13,  5}
    };

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [63:0] value;
        logic        typed;
        t_result     first;
        t_result     second;
    } t_row;

    localparam t_result BLACK_PX = '{out_byte: 8'h80, row_end: 1'b0};
    localparam t_result WHITE_PX = '{out_byte: 8'h00, row_end: 1'b0};
    localparam t_result PAD_END  = '{out_byte: 8'h00, row_end: 1'b1};
    localparam t_result NO_RES   = '{out_byte: 8'h00, row_end: 1'b0};

    localparam t_row DIRECTED [45] = '{
        // reset config: width 1, black palette, every byte gives a dot and a pad
        '{ROW_BYTE, REG_PAL_0,       64'h00,   1'b1, BLACK_PX, PAD_END},
        '{ROW_BYTE, REG_PAL_0,       64'hFF,   1'b1, BLACK_PX, PAD_END},
        '{ROW_REG,  REG_PAL_0,       ALL_ONES, 1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_PAL_1,       ALL_ONES, 1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_PAL_2,       ALL_ONES, 1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_PAL_3,       ALL_ONES, 1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_PAL_4,       ALL_ONES, 1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_PAL_5,       ALL_ONES, 1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h5A,   1'b1, WHITE_PX, PAD_END},
        // entries 0 and 1 black; color count zero folds every index onto entry 0
        '{ROW_REG,  REG_PAL_0,       64'h0,    1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_COLOR_COUNT, 64'd0,    1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'hFF,   1'b1, BLACK_PX, PAD_END},
        '{ROW_REG,  REG_COLOR_COUNT, 64'd31,   1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_IMAGE_WIDTH, 64'd0,    1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h1F,   1'b1, BLACK_PX, PAD_END},
        // mixed grays, odd width with a partial last byte
        '{ROW_REG,  REG_PAL_1,  64'h0123_4567_89AB_CDEF, 1'b0, NO_RES, NO_RES},
        '{ROW_REG,  REG_PAL_2,  64'h7F80_8081_4041_C0C1, 1'b0, NO_RES, NO_RES},
        '{ROW_REG,  REG_COLOR_COUNT, 64'd5,    1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_IMAGE_WIDTH, 64'd7,    1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h01,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h23,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h45,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h67,   1'b0, NO_RES,   NO_RES},
        // two full bytes per row, no padding
        '{ROW_REG,  REG_IMAGE_WIDTH, 64'd16,   1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_COLOR_COUNT, 64'd16,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h89,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'hAB,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'hCD,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'hEF,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h10,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h32,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h54,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h76,   1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_IMAGE_WIDTH, 64'd9,    1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'hF0,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h0F,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h96,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h69,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'hC3,   1'b0, NO_RES,   NO_RES},
        // shrink the width under the current column: next byte closes the row
        '{ROW_REG,  REG_IMAGE_WIDTH, 64'd16,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h12,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h34,   1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h56,   1'b0, NO_RES,   NO_RES},
        '{ROW_REG,  REG_IMAGE_WIDTH, 64'd4,    1'b0, NO_RES,   NO_RES},
        '{ROW_BYTE, REG_PAL_0,       64'h78,   1'b0, NO_RES,   NO_RES}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_src_byte = 8'h00;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_row_end;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // dither model state and register copies
    logic [PAL_BITS-1:0] pal        = '0;
    logic [CC_W-1:0]     cfg_colors = CC_RESET;
    logic [IMG_W-1:0]    cfg_width  = IMG_RESET;
    int unsigned         col        = 0;
    logic [1:0]          row_phase  = 2'd0;
    logic [7:0]          dot_acc    = 8'h00;
    logic                row_odd    = 1'b0;

    t_result     pending_bytes [$];
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    logic        gaps_on    = 1'b1;

    palette_bayer_dither_1bit_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_src_byte (i_src_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_row_end  (o_row_end),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void emit_byte(input logic [7:0] b);
        pending_bytes.push_back('{out_byte: b, row_end: 1'b0});
        row_odd = ~row_odd;
    endfunction

    // Work out the output bytes caused by one source byte.
    function automatic void rasterize_src(input logic [7:0] src);
        int unsigned w, c, stop, idx, lum, thr, n;
        t_result     last;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
        stop = col;
        n = 0;
        for (int k = 0; k < 2; k++) begin
            c = col + k;
            if (c >= w)
                break;
            idx = (k == 0) ? src[7:4] : src[3:0];
            if (idx >= cfg_colors)
                idx = 0;
            lum = (int'(pal[idx*24+16 +: 8]) + int'(pal[idx*24+8 +: 8]) +
                   int'(pal[idx*24 +: 8])) / 3;
            thr = DOT_CELL[row_phase][c % 4] * 16 + 8;
            if (lum <= thr)
                dot_acc = dot_acc | (8'h80 >> (c % 8));
            stop = c + 1;
            if (c % 8 == 7) begin
                emit_byte(dot_acc);
                n++;
                dot_acc = 8'h00;
            end
        end
        if (col + 2 >= w) begin
            if (stop % 8 != 0) begin
                emit_byte(dot_acc);
                n++;
            end
            if (row_odd) begin
                emit_byte(8'h00);
                n++;
            end
            if (n > 0) begin
                last = pending_bytes.pop_back();
                last.row_end = 1'b1;
                pending_bytes.push_back(last);
            end
            col = 0;
            dot_acc = 8'h00;
            row_odd = 1'b0;
            row_phase = row_phase + 2'd1;
        end else begin
            col = col + 2;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input t_result first, input t_result second);
        int unsigned mark;
        if (gaps_on && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 19);
        end
        i_valid <= 1'b1;
        i_src_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        mark = pending_bytes.size();
        rasterize_src(b);
        if (typed) begin
            while (pending_bytes.size() > mark)
                void'(pending_bytes.pop_back());
            pending_bytes.push_back(first);
            pending_bytes.push_back(second);
        end
    endtask

    // Drop valid, wait for every expected byte, then cover zero-result items in flight.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_bytes.size() != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_COLOR_COUNT: cfg_colors = val[CC_W-1:0];
            REG_IMAGE_WIDTH: cfg_width = val[IMG_W-1:0];
            default:         pal[int'(idx)*64 +: 64] = val;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random stalls, compare each transfer with the oldest expectation
    initial begin : result_check
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %h row_end %b", o_out_byte, o_row_end);
                    mismatches++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, o_out_byte);
                        mismatches++;
                    end
                    if (o_row_end !== want.row_end) begin
                        $error("row_end: expected %b, got %b", want.row_end, o_row_end);
                        mismatches++;
                    end
                end
            end
            i_ready <= !(gaps_on && $urandom_range(99) < 19);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [PAL_BITS-1:0] new_pal;
        logic [IMG_W-1:0]    new_width;
        logic [CC_W-1:0]     new_colors;
        int unsigned         lv, pick, n_items, phase_no, sent;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_REG) begin
                settle();
                cfg_write(DIRECTED[i].idx, DIRECTED[i].value);
            end else begin
                send_byte(DIRECTED[i].value[7:0], DIRECTED[i].typed,
                          DIRECTED[i].first, DIRECTED[i].second);
            end
        end

        // part of a row at a width that saturates to the maximum
        settle();
        cfg_write(REG_IMAGE_WIDTH, 64'hFFF);
        repeat (WIDE_BYTES) send_byte(8'($urandom_range(255)), 1'b0, NO_RES, NO_RES);

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            gaps_on = (phase_no != STEADY_PHASE);
            pick = $urandom_range(99);
            for (int e = 0; e < PAL_ENTRIES; e++) begin
                if (pick < 40) begin
                    // grays right at a threshold, one under or one over
                    lv = DOT_CELL[$urandom_range(3)][$urandom_range(3)] * 16 + 7 +
                         $urandom_range(2);
                    new_pal[e*24 +: 24] = {lv[7:0], lv[7:0], 8'(lv + $urandom_range(2))};
                end else if (pick < 75) begin
                    new_pal[e*24 +: 24] = 24'($urandom);
                end else begin
                    new_pal[e*24 +: 24] = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                end
            end
            for (int k = 0; k < 6; k++)
                cfg_write(REG_PAL_0 + 3'(k), new_pal[k*64 +: 64]);

            pick = $urandom_range(99);
            if (pick < 8)
                new_colors = '0;
            else if (pick < 16)
                new_colors = CC_W'($urandom_range(17, 31));
            else if (pick < 30)
                new_colors = CC_W'(PAL_ENTRIES);
            else
                new_colors = CC_W'($urandom_range(1, 16));
            cfg_write(REG_COLOR_COUNT, 64'(new_colors));

            pick = $urandom_range(99);
            if (pick < 4)
                new_width = '0;
            else if (pick < 8)
                new_width = IMG_W'(MAX_W);
            else if (pick < 12)
                new_width = IMG_W'($urandom_range(MAX_W + 1, 4095));
            else if (pick < 20)
                new_width = IMG_W'(1);
            else
                new_width = IMG_W'($urandom_range(2, 40));
            cfg_write(REG_IMAGE_WIDTH, 64'(new_width));

            n_items = (phase_no == STEADY_PHASE) ? 150 : $urandom_range(4, 50);
            repeat (n_items) send_byte(8'($urandom_range(255)), 1'b0, NO_RES, NO_RES);
            sent += n_items;
            phase_no++;
        end

        gaps_on = 1'b1;
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
